// ===== src/whi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the wave header inspector.
// Used by whi_parser, wave_header_inspector_top, the checker and the testbench; depends on nothing.
package whi_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned TagW    = 16;
	localparam int unsigned OffsetW = 32;
	localparam int unsigned LimitW  = 8;

	localparam logic [LimitW-1:0] MaxChunksReset = 8'd16;

	localparam logic [31:0] MarkRiff = 32'h5249_4646;
	localparam logic [31:0] MarkWave = 32'h5741_5645;
	localparam logic [31:0] MarkFmt  = 32'h666D_7420;
	localparam logic [31:0] MarkData = 32'h6461_7461;

	localparam logic [TagW-1:0] TagPcm = 16'h0001;
	localparam logic [TagW-1:0] TagMp3 = 16'h0055;

	// Byte indexes inside the fixed headers.
	localparam logic [3:0] RiffLastIdx  = 4'd3;
	localparam logic [3:0] WaveLastIdx  = 4'd11;
	localparam logic [3:0] ChunkIdBytes = 4'd4;
	localparam logic [3:0] ChunkLastIdx = 4'd7;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_CHUNK  = 3'd1,
		PH_TAG    = 3'd2,
		PH_SKIP   = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		VERDICT_BAD = 2'd0,
		VERDICT_PCM = 2'd1,
		VERDICT_MP3 = 2'd2
	} verdict_t;

	typedef struct packed {
		logic                 valid;
		verdict_t             verdict;
		logic [TagW-1:0]      tag;
		logic [OffsetW-1:0]   offset;
	} whi_result_t;

endpackage

// ===== src/whi_parser.sv =====
`timescale 1ns / 1ps
// Byte-wise parser state of the wave header inspector: one step per accepted byte.
// Depends on whi_pkg.
module whi_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [whi_pkg::ByteW-1:0]      data_byte,
	input  logic                           end_of_file,
	input  logic [whi_pkg::LimitW-1:0]     max_chunks,
	output whi_pkg::whi_result_t           result
);

	whi_pkg::phase_t                  phase_q, phase_nx;
	logic [3:0]                       fc_q, fc_nx;
	logic [31:0]                      id_q, id_nx;
	logic [31:0]                      len_q, len_nx;
	logic [32:0]                      skip_q, skip_nx;
	logic [whi_pkg::TagW-1:0]         tag_q, tag_nx;
	logic [whi_pkg::OffsetW-1:0]      pos_q, pos_nx;
	logic [whi_pkg::LimitW-1:0]       cs_q, cs_nx;

	always_comb begin
		logic                     was_done;
		logic                     go_next;
		logic                     skip_start;
		logic [31:0]              skip_len;
		logic [31:0]              id_shift;
		logic [whi_pkg::OffsetW-1:0] pos_inc;

		phase_nx = phase_q;
		fc_nx    = fc_q;
		id_nx    = id_q;
		len_nx   = len_q;
		skip_nx  = skip_q;
		tag_nx   = tag_q;
		pos_nx   = pos_q;
		cs_nx    = cs_q;
		result.valid   = 1'b0;
		result.verdict = whi_pkg::VERDICT_BAD;
		result.offset  = '0;
		go_next    = 1'b0;
		skip_start = 1'b0;
		skip_len   = len_q;
		id_shift   = {id_q[23:0], data_byte};
		pos_inc    = pos_q + 32'd1;
		was_done   = (phase_q >= whi_pkg::PH_DONE);

		if (!was_done) begin
			pos_nx = pos_inc;
		end

		unique case (phase_q)
			whi_pkg::PH_HEADER: begin
				id_nx = id_shift;
				if (fc_q == whi_pkg::RiffLastIdx && id_shift != whi_pkg::MarkRiff) begin
					result.valid = 1'b1;
				end else if (fc_q == whi_pkg::WaveLastIdx) begin
					if (id_shift != whi_pkg::MarkWave) begin
						result.valid = 1'b1;
					end else begin
						go_next = 1'b1;
					end
				end else begin
					fc_nx = fc_q + 4'd1;
				end
			end
			whi_pkg::PH_CHUNK: begin
				if (fc_q < whi_pkg::ChunkIdBytes) begin
					id_nx = id_shift;
				end else begin
					len_nx = len_q | ({24'd0, data_byte} << {fc_q[1:0], 3'b000});
				end
				if (fc_q < whi_pkg::ChunkLastIdx) begin
					fc_nx = fc_q + 4'd1;
				end else begin
					fc_nx = 4'd0;
					cs_nx = cs_q + 8'd1;
					if (id_q == whi_pkg::MarkFmt) begin
						if (len_nx < 32'd2) begin
							result.valid = 1'b1;
						end else begin
							phase_nx = whi_pkg::PH_TAG;
						end
					end else if (id_q == whi_pkg::MarkData) begin
						// The data chunk ends the walk; an unknown tag still reports
						// the tag and the offset under a bad verdict.
						result.valid  = 1'b1;
						result.offset = pos_inc;
						if (tag_q == whi_pkg::TagPcm) begin
							result.verdict = whi_pkg::VERDICT_PCM;
						end else if (tag_q == whi_pkg::TagMp3) begin
							result.verdict = whi_pkg::VERDICT_MP3;
						end
					end else begin
						skip_start = 1'b1;
						skip_len   = len_nx;
					end
				end
			end
			whi_pkg::PH_TAG: begin
				if (fc_q == 4'd0) begin
					tag_nx = {8'd0, data_byte};
					fc_nx  = 4'd1;
				end else begin
					tag_nx     = {data_byte, tag_q[7:0]};
					fc_nx      = 4'd0;
					skip_start = 1'b1;
					skip_len   = len_q - 32'd2;
				end
			end
			whi_pkg::PH_SKIP: begin
				skip_nx = skip_q - 33'd1;
				if (skip_nx == 33'd0) begin
					go_next = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Body plus one pad byte when the length is odd.
		if (skip_start) begin
			skip_nx = {1'b0, skip_len} + {32'd0, skip_len[0]};
			if (skip_len == 32'd0) begin
				go_next = 1'b1;
			end else begin
				phase_nx = whi_pkg::PH_SKIP;
			end
		end

		if (go_next) begin
			fc_nx  = 4'd0;
			id_nx  = '0;
			len_nx = '0;
			if (cs_nx >= max_chunks) begin
				result.valid = 1'b1;
			end else begin
				phase_nx = whi_pkg::PH_CHUNK;
			end
		end

		if (result.valid) begin
			phase_nx = whi_pkg::PH_DONE;
		end

		// A file that ends with no verdict yet gets a bad one.
		if (end_of_file) begin
			if (!was_done && !result.valid) begin
				result.valid   = 1'b1;
				result.verdict = whi_pkg::VERDICT_BAD;
				result.offset  = '0;
			end
			phase_nx = whi_pkg::PH_HEADER;
			fc_nx    = '0;
			id_nx    = '0;
			len_nx   = '0;
			skip_nx  = '0;
			pos_nx   = '0;
			cs_nx    = '0;
		end

		result.tag = tag_nx;
		if (end_of_file) begin
			tag_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= whi_pkg::PH_HEADER;
			fc_q    <= '0;
			id_q    <= '0;
			len_q   <= '0;
			skip_q  <= '0;
			tag_q   <= '0;
			pos_q   <= '0;
			cs_q    <= '0;
		end else if (step) begin
			phase_q <= phase_nx;
			fc_q    <= fc_nx;
			id_q    <= id_nx;
			len_q   <= len_nx;
			skip_q  <= skip_nx;
			tag_q   <= tag_nx;
			pos_q   <= pos_nx;
			cs_q    <= cs_nx;
		end
	end

endmodule

// ===== src/wave_header_inspector_top.sv =====
`timescale 1ns / 1ps
// Top level of the wave header inspector: config register, parser and result register.
// Depends on whi_pkg and whi_parser.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_ready, data_byte, end_of_file | to block
//  out     | out_valid, out_ready, verdict, format_tag, | from block
//          | data_offset                                |
//  cfg     | cfg_valid, cfg_ready, max_chunks           | to block
//
// One byte request is taken every cycle while no verdict waits on out_ready; the parser
// state and any verdict for that byte are registered at the edge that takes the byte.
// Throughput is set by the single result register: a new byte is taken while a
// verdict is held only if that verdict leaves in the same cycle.
// Reset clears the parser to the start of a file and loads max_chunks with 16.
// Configuration requests are always taken and should arrive only while idle.
module wave_header_inspector_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [whi_pkg::ByteW-1:0]     data_byte,
	input  logic                          end_of_file,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    verdict,
	output logic [whi_pkg::TagW-1:0]      format_tag,
	output logic [whi_pkg::OffsetW-1:0]   data_offset,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [whi_pkg::LimitW-1:0]    max_chunks
);

	logic [whi_pkg::LimitW-1:0] max_chunks_q;
	logic                       in_take;
	whi_pkg::whi_result_t       result;
	logic                       out_valid_q;
	whi_pkg::verdict_t          verdict_q;
	logic [whi_pkg::TagW-1:0]   tag_q;
	logic [whi_pkg::OffsetW-1:0] offset_q;

	// The single register accepts writes at any time.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chunks_q <= whi_pkg::MaxChunksReset;
		end else if (cfg_valid) begin
			max_chunks_q <= max_chunks;
		end
	end

	// A byte may enter whenever the result register is free or is being emptied.
	assign in_ready = !out_valid_q || out_ready;
	assign in_take  = in_valid && in_ready;

	whi_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (in_take),
		.data_byte   (data_byte),
		.end_of_file (end_of_file),
		.max_chunks  (max_chunks_q),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take && result.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload of the result register; loaded only when a verdict is produced.
	always_ff @(posedge clk) begin
		if (in_take && result.valid) begin
			verdict_q <= result.verdict;
			tag_q     <= result.tag;
			offset_q  <= result.offset;
		end
	end

	assign out_valid   = out_valid_q;
	assign verdict     = verdict_q;
	assign format_tag  = tag_q;
	assign data_offset = offset_q;

endmodule

// ===== src/whi_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the wave header inspector, bound to the top level.
// Depends on whi_pkg and wave_header_inspector_top.
module whi_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [1:0]                  verdict,
	input logic [whi_pkg::TagW-1:0]    format_tag,
	input logic [whi_pkg::OffsetW-1:0] data_offset
);

	// A verdict never uses the spare code.
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict == whi_pkg::VERDICT_BAD || verdict == whi_pkg::VERDICT_PCM
			|| verdict == whi_pkg::VERDICT_MP3))
		else $error("verdict carries an unused code");

	// A good verdict agrees with the tag it reports.
	a_tag_match: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (verdict == whi_pkg::VERDICT_PCM)) |-> (format_tag == whi_pkg::TagPcm))
		else $error("PCM verdict without PCM tag");

	a_mp3_match: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (verdict == whi_pkg::VERDICT_MP3)) |-> (format_tag == whi_pkg::TagMp3))
		else $error("MP3 verdict without MP3 tag");

	// A held verdict blocks new bytes.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("byte taken while a verdict is stalled");

	// A stalled verdict keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(verdict) && $stable(format_tag)
			&& $stable(data_offset)))
		else $error("stalled verdict changed");

endmodule

bind wave_header_inspector_top whi_checker u_whi_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.verdict     (verdict),
	.format_tag  (format_tag),
	.data_offset (data_offset)
);

// ===== verif/wave_header_inspector_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for wave_header_inspector_top: streams RIFF/WAVE files byte by byte,
// predicts each verdict with a behavioral chunk walker and checks every result request.
// Depends on whi_pkg, wave_header_inspector_top and its submodule whi_parser.
module wave_header_inspector_top_tb;

	localparam int HalfPeriod  = 5;
	localparam int ResetCycles = 10;
	// A verdict is registered when its byte is taken; the drain leaves a comfortable margin.
	localparam int DrainCycles = 8;
	// Cycles without any accepted request before the run is declared hung.
	localparam int QuietLimit  = 2000;
	localparam int MaxReported = 10;
	// Random traffic budget per phase, counted in accepted byte requests.
	localparam int PhaseBytes  = 175;

	// Chunk ids that the block treats as ordinary chunks to be skipped.
	localparam logic [31:0] MarkList = 32'h4C49_5354;
	localparam logic [31:0] MarkFact = 32'h6661_6374;

	typedef struct packed {
		whi_pkg::verdict_t                verdict;
		logic [whi_pkg::TagW-1:0]         tag;
		logic [whi_pkg::OffsetW-1:0]      offset;
	} verdict_rec_t;

	// Every input of the block holds a known value from time zero.
	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          in_valid    = 1'b0;
	logic                          in_ready;
	logic [whi_pkg::ByteW-1:0]     data_byte   = '0;
	logic                          end_of_file = 1'b0;
	logic                          out_valid;
	logic                          out_ready   = 1'b0;
	logic [1:0]                    verdict;
	logic [whi_pkg::TagW-1:0]      format_tag;
	logic [whi_pkg::OffsetW-1:0]   data_offset;
	logic                          cfg_valid   = 1'b0;
	logic                          cfg_ready;
	logic [whi_pkg::LimitW-1:0]    max_chunks  = whi_pkg::MaxChunksReset;

	// Idling switches: the sender inserts gaps before bytes, the receiver stalls each verdict.
	bit tx_gaps_on   = 1'b0;
	bit rx_stalls_on = 1'b0;

	verdict_rec_t pending_verdicts[$];
	logic [7:0]   file_q[$];
	int           mismatches   = 0;
	int           sent_bytes   = 0;
	int           quiet_cycles = 0;

	always #HalfPeriod clk = ~clk;

	wave_header_inspector_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.end_of_file (end_of_file),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.verdict     (verdict),
		.format_tag  (format_tag),
		.data_offset (data_offset),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.max_chunks  (max_chunks)
	);

	// ------------------------------------------------------------------
	// Chunk walker. It mirrors the parser state after reset and is
	// advanced once per accepted byte request by the checker below.
	// ------------------------------------------------------------------
	whi_pkg::phase_t               walk_phase  = whi_pkg::PH_HEADER;
	logic [3:0]                    walk_idx    = '0;
	logic [31:0]                   walk_id     = '0;
	logic [31:0]                   walk_len    = '0;
	logic [32:0]                   walk_skip   = '0;
	logic [whi_pkg::TagW-1:0]      walk_tag    = '0;
	logic [31:0]                   walk_pos    = '0;
	logic [7:0]                    walk_chunks = '0;
	logic [whi_pkg::LimitW-1:0]    chunk_limit = whi_pkg::MaxChunksReset;

	// Issue a verdict for the current file; the walker then ignores bytes until end of file.
	task automatic conclude(input whi_pkg::verdict_t v, input logic [31:0] off,
			output logic got, output verdict_rec_t rec);
		rec.verdict = v;
		rec.tag     = walk_tag;
		rec.offset  = off;
		walk_phase  = whi_pkg::PH_DONE;
		got         = 1'b1;
	endtask

	// A new chunk header starts here, unless the chunk budget is already spent.
	task automatic open_chunk(output logic got, output verdict_rec_t rec);
		got      = 1'b0;
		rec      = '0;
		walk_idx = '0;
		walk_id  = '0;
		walk_len = '0;
		if (walk_chunks >= chunk_limit)
			conclude(whi_pkg::VERDICT_BAD, '0, got, rec);
		else
			walk_phase = whi_pkg::PH_CHUNK;
	endtask

	// Bodies are padded to an even length; an empty body goes straight to the next header.
	task automatic begin_skip(input logic [31:0] len, output logic got, output verdict_rec_t rec);
		got       = 1'b0;
		rec       = '0;
		walk_skip = {1'b0, len} + {32'd0, len[0]};
		if (walk_skip == '0)
			open_chunk(got, rec);
		else
			walk_phase = whi_pkg::PH_SKIP;
	endtask

	task automatic walk_byte(input logic [7:0] b, input logic eof,
			output logic got, output verdict_rec_t rec);
		logic done_before;
		got = 1'b0;
		rec = '0;
		done_before = (walk_phase >= whi_pkg::PH_DONE);
		if (!done_before) begin
			walk_pos = walk_pos + 32'd1;
			case (walk_phase)
				whi_pkg::PH_HEADER: begin
					walk_id = {walk_id[23:0], b};
					if (walk_idx == whi_pkg::RiffLastIdx && walk_id != whi_pkg::MarkRiff) begin
						conclude(whi_pkg::VERDICT_BAD, '0, got, rec);
					end else if (walk_idx == whi_pkg::WaveLastIdx) begin
						if (walk_id != whi_pkg::MarkWave)
							conclude(whi_pkg::VERDICT_BAD, '0, got, rec);
						else
							open_chunk(got, rec);
					end else begin
						walk_idx = walk_idx + 4'd1;
					end
				end
				whi_pkg::PH_CHUNK: begin
					// Four id bytes in file order, then a little-endian length.
					if (walk_idx < whi_pkg::ChunkIdBytes)
						walk_id = {walk_id[23:0], b};
					else
						walk_len = walk_len |
							(32'(b) << (8 * (walk_idx - whi_pkg::ChunkIdBytes)));
					if (walk_idx < whi_pkg::ChunkLastIdx) begin
						walk_idx = walk_idx + 4'd1;
					end else begin
						walk_idx    = '0;
						walk_chunks = walk_chunks + 8'd1;
						if (walk_id == whi_pkg::MarkFmt) begin
							// A fmt chunk too short to hold a tag is rejected outright.
							if (walk_len < 32'd2)
								conclude(whi_pkg::VERDICT_BAD, '0, got, rec);
							else
								walk_phase = whi_pkg::PH_TAG;
						end else if (walk_id == whi_pkg::MarkData) begin
							// Unknown tags still report the tag and the data offset.
							case (walk_tag)
								whi_pkg::TagPcm:
									conclude(whi_pkg::VERDICT_PCM, walk_pos, got, rec);
								whi_pkg::TagMp3:
									conclude(whi_pkg::VERDICT_MP3, walk_pos, got, rec);
								default:
									conclude(whi_pkg::VERDICT_BAD, walk_pos, got, rec);
							endcase
						end else begin
							begin_skip(walk_len, got, rec);
						end
					end
				end
				whi_pkg::PH_TAG: begin
					if (walk_idx == '0) begin
						walk_tag = {8'h00, b};
						walk_idx = 4'd1;
					end else begin
						walk_tag[15:8] = b;
						walk_idx       = '0;
						begin_skip(walk_len - 32'd2, got, rec);
					end
				end
				whi_pkg::PH_SKIP: begin
					walk_skip = walk_skip - 33'd1;
					if (walk_skip == '0)
						open_chunk(got, rec);
				end
				default: ;
			endcase
		end
		if (eof) begin
			// A file that ends undecided is bad, with no data offset.
			if (!done_before && !got)
				conclude(whi_pkg::VERDICT_BAD, '0, got, rec);
			walk_phase  = whi_pkg::PH_HEADER;
			walk_idx    = '0;
			walk_id     = '0;
			walk_len    = '0;
			walk_skip   = '0;
			walk_tag    = '0;
			walk_pos    = '0;
			walk_chunks = '0;
		end
	endtask

	// ------------------------------------------------------------------
	// Checker. Everything is sampled at the rising edge, before the
	// testbench's nonblocking updates of that edge take effect.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		logic         got;
		verdict_rec_t rec;
		verdict_rec_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				chunk_limit = max_chunks;
			if (out_valid && out_ready) begin
				if (pending_verdicts.size() == 0) begin
					if (mismatches < MaxReported)
						$display("unexpected result request: verdict %0d tag %h offset %h",
							verdict, format_tag, data_offset);
					mismatches++;
				end else begin
					want = pending_verdicts.pop_front();
					if (verdict !== want.verdict || format_tag !== want.tag ||
							data_offset !== want.offset) begin
						if (mismatches < MaxReported)
							$display({"mismatch: expected verdict %0d tag %h offset %h, ",
								"got verdict %0d tag %h offset %h"},
								want.verdict, want.tag, want.offset,
								verdict, format_tag, data_offset);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready) begin
				sent_bytes++;
				walk_byte(data_byte, end_of_file, got, rec);
				if (got)
					pending_verdicts.push_back(rec);
			end
		end
	end

	// Watchdog: a correct run never goes this long without moving a request.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QuietLimit) begin
				$display("wave_header_inspector_top verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Result receiver. With stalls on, ready stays low until a verdict is
	// offered and then rises after a random hold, so every verdict sits in
	// the result register for a while and pushes back on the byte stream.
	initial begin : result_sink
		int hold;
		forever begin
			if (!rx_stalls_on) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ready <= 1'b0;
				do @(posedge clk); while (!out_valid);
				hold = $urandom_range(0, 5);
				repeat (hold) @(posedge clk);
				out_ready <= 1'b1;
				do @(posedge clk); while (!(out_valid && out_ready));
			end
		end
	end

	// ------------------------------------------------------------------
	// Byte request driver and file builders.
	// ------------------------------------------------------------------
	// Valid stays high between back-to-back bytes; a gap lowers it first.
	task automatic send_byte(input logic [7:0] b, input logic eof);
		int gap;
		gap = tx_gaps_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		data_byte   <= b;
		end_of_file <= eof;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	task automatic send_file();
		for (int i = 0; i < file_q.size(); i++)
			send_byte(file_q[i], i == file_q.size() - 1);
		file_q.delete();
	endtask

	// Stop sending and let every expected verdict drain before touching the register.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_limit(input logic [whi_pkg::LimitW-1:0] value);
		cfg_valid  <= 1'b1;
		max_chunks <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
	endtask

	// Marks go out most significant byte first, which is file order for ids.
	task automatic add_mark(input logic [31:0] m);
		file_q.push_back(m[31:24]);
		file_q.push_back(m[23:16]);
		file_q.push_back(m[15:8]);
		file_q.push_back(m[7:0]);
	endtask

	task automatic add_random_bytes(input int n);
		repeat (n) file_q.push_back(8'($urandom));
	endtask

	task automatic add_riff_header();
		add_mark(whi_pkg::MarkRiff);
		add_random_bytes(4);
		add_mark(whi_pkg::MarkWave);
	endtask

	task automatic add_chunk_header(input logic [31:0] id, input logic [31:0] len);
		add_mark(id);
		add_mark({len[7:0], len[15:8], len[23:16], len[31:24]});
	endtask

	task automatic add_chunk(input logic [31:0] id, input logic [31:0] len);
		add_chunk_header(id, len);
		add_random_bytes(int'(len) + int'(len[0]));
	endtask

	task automatic add_fmt(input logic [31:0] len, input logic [whi_pkg::TagW-1:0] tag);
		add_chunk_header(whi_pkg::MarkFmt, len);
		if (len >= 32'd2) begin
			file_q.push_back(tag[7:0]);
			file_q.push_back(tag[15:8]);
			add_random_bytes(int'(len) - 2 + int'(len[0]));
		end
	endtask

	// Tags lean on the two decodable ones and their near misses.
	function automatic logic [whi_pkg::TagW-1:0] pick_tag();
		case ($urandom_range(0, 5))
			0:       return whi_pkg::TagPcm;
			1:       return whi_pkg::TagMp3;
			2:       return 16'h0000;
			3:       return 16'hFFFF;
			4:       return {8'h01, whi_pkg::TagMp3[7:0]};
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_random_chunk();
		logic [31:0] len;
		logic [31:0] id;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			case ($urandom_range(0, 5))
				0:       len = 32'd0;
				1:       len = 32'd1;
				2:       len = 32'd2;
				3:       len = 32'd3;
				4:       len = 32'd18;
				default: len = 32'd16;
			endcase
			add_fmt(len, pick_tag());
		end else if (sel < 8) begin
			case ($urandom_range(0, 4))
				0:       id = MarkList;
				1:       id = MarkFact;
				2:       id = whi_pkg::MarkData ^ (32'd1 << $urandom_range(0, 31));
				3:       id = whi_pkg::MarkFmt ^ (32'd1 << $urandom_range(0, 31));
				default: id = $urandom;
			endcase
			add_chunk(id, $urandom_range(0, 9));
		end else if (sel == 8) begin
			// A length far beyond the file: the walk is still skipping when the file ends.
			add_chunk_header($urandom, $urandom);
			add_random_bytes($urandom_range(0, 6));
		end else begin
			add_fmt(32'd17, pick_tag());
		end
	endtask

	// Mostly well-formed files with random chunks, plus noise and damaged headers.
	task automatic build_random_file();
		int kind;
		int pos;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			add_random_bytes($urandom_range(1, 12));
		end else if (kind < 18) begin
			add_riff_header();
			// Damage one byte of either mark; the size field in between is never checked.
			pos = $urandom_range(0, 7);
			if (pos > 3)
				pos += 4;
			file_q[pos] ^= 8'(1 << $urandom_range(0, 7));
			add_random_bytes($urandom_range(0, 4));
		end else begin
			add_riff_header();
			repeat ($urandom_range(0, 5)) add_random_chunk();
			if ($urandom_range(0, 9) < 8) begin
				add_chunk_header(whi_pkg::MarkData, $urandom);
				add_random_bytes($urandom_range(0, 3));
			end else begin
				add_random_bytes($urandom_range(0, 3));
			end
			if ($urandom_range(0, 9) == 0)
				file_q = file_q[0:$urandom_range(0, file_q.size() - 1)];
		end
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------
	// Files that end before any verdict, including the byte extremes as one-byte files
	// and a file cut off while skipping the body of a fmt chunk whose tag was read.
	task automatic test_early_end();
		file_q.push_back(8'hFF);
		send_file();
		file_q.push_back(8'h00);
		send_file();
		add_mark(whi_pkg::MarkRiff);
		void'(file_q.pop_back());
		send_file();
		add_riff_header();
		add_fmt(32'd16, whi_pkg::TagMp3);
		file_q = file_q[0:23];
		send_file();
	endtask

	// A wrong RIFF or WAVE mark is caught on its last byte; later bytes are ignored until end of file.
	task automatic test_missing_marks();
		add_mark({whi_pkg::MarkRiff[31:8], 8'h58});
		send_file();
		add_mark({8'h58, whi_pkg::MarkRiff[23:0]});
		add_random_bytes(3);
		send_file();
		add_mark(whi_pkg::MarkRiff);
		add_random_bytes(4);
		add_mark({whi_pkg::MarkWave[31:8], 8'h58});
		send_file();
	endtask

	// PCM behind an odd-length chunk that needs a pad byte, then MP3 with trailing bytes.
	task automatic test_known_formats();
		add_riff_header();
		add_chunk(MarkList, 32'd3);
		add_fmt(32'd16, whi_pkg::TagPcm);
		add_chunk_header(whi_pkg::MarkData, $urandom);
		send_file();
		add_riff_header();
		add_fmt(32'd16, whi_pkg::TagMp3);
		add_chunk_header(whi_pkg::MarkData, $urandom);
		add_random_bytes(2);
		send_file();
	endtask

	// Unknown tag, data with no fmt at all, and a later fmt chunk replacing an earlier tag.
	task automatic test_odd_tags();
		add_riff_header();
		add_fmt(32'd2, 16'hFFFF);
		add_chunk_header(whi_pkg::MarkData, $urandom);
		send_file();
		add_riff_header();
		add_chunk_header(whi_pkg::MarkData, $urandom);
		send_file();
		add_riff_header();
		add_fmt(32'd18, whi_pkg::TagMp3);
		add_fmt(32'd2, whi_pkg::TagPcm);
		add_chunk_header(whi_pkg::MarkData, $urandom);
		send_file();
	endtask

	// fmt chunks too short to carry a tag.
	task automatic test_short_fmt();
		add_riff_header();
		add_fmt(32'd1, whi_pkg::TagPcm);
		send_file();
		add_riff_header();
		add_fmt(32'd0, whi_pkg::TagPcm);
		add_random_bytes(2);
		send_file();
	endtask

	// With a budget of one chunk, only a data chunk in first place can be reached.
	task automatic test_chunk_limit();
		wait_idle();
		write_limit(8'd1);
		add_riff_header();
		add_chunk(MarkFact, 32'd0);
		add_chunk_header(whi_pkg::MarkData, $urandom);
		send_file();
		add_riff_header();
		add_fmt(32'd16, whi_pkg::TagPcm);
		add_chunk_header(whi_pkg::MarkData, $urandom);
		send_file();
		add_riff_header();
		add_chunk_header(whi_pkg::MarkData, $urandom);
		send_file();
	endtask

	task automatic test_random_traffic(input logic [whi_pkg::LimitW-1:0] limit, input bit tx_on,
			input bit rx_on);
		int start_bytes;
		wait_idle();
		write_limit(limit);
		tx_gaps_on   = tx_on;
		rx_stalls_on = rx_on;
		start_bytes  = sent_bytes;
		while (sent_bytes - start_bytes < PhaseBytes) begin
			build_random_file();
			send_file();
		end
	endtask

	initial begin
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed files run at the reset budget of sixteen chunks, the chunk-limit test at one, with idling on both sides.
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		test_early_end();
		test_missing_marks();
		test_known_formats();
		test_odd_tags();
		test_short_fmt();
		test_chunk_limit();
		// Random phases sweep the chunk budget, including both ends, and the idling mix.
		test_random_traffic(8'd1, 1'b1, 1'b1);
		test_random_traffic(8'd255, 1'b0, 1'b0);
		test_random_traffic(8'($urandom_range(2, 8)), 1'b1, 1'b0);
		test_random_traffic(whi_pkg::MaxChunksReset, 1'b0, 1'b1);
		test_random_traffic(8'($urandom_range(2, 8)), 1'b1, 1'b1);
		wait_idle();
		if (mismatches == 0)
			$display("wave_header_inspector_top verification clean");
		else
			$display("wave_header_inspector_top verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/whi_pkg.sv
src/whi_parser.sv
src/wave_header_inspector_top.sv
src/whi_checker.sv
verif/wave_header_inspector_top_tb.sv
